// ----- rtl/gops_pkg.sv -----
// Shared types, constants and direction tables for the grid octile path search.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package gops_pkg;

  localparam int MAX_SIDE = 64;
  localparam int COORD_W  = 6;
  localparam int CELL_W   = 2 * COORD_W;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int SIDE_W   = 7;
  localparam int COST_W   = 32;
  localparam int DIR_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [COST_W-1:0] STEP_STRAIGHT = 32'd65536;
  localparam logic [COST_W-1:0] STEP_DIAG     = 32'd92682;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_UNREACH  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       clr_start;
    logic       clr_step;
    logic       init_start;
    logic       pop;
    logic       pop_take;
    logic       cur_rd;
    logic       cur_take;
    logic       d_inc;
    logic       nb_rd;
    logic       nb_upd;
    logic       tr_init;
    logic       tr_chk;
    logic       tr_step;
    logic       append;
    logic       em_rd;
    logic       em_load;
    logic       err_load;
    logic [1:0] err_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_req;
    logic clr_done;
    logic q_empty;
    logic q_full;
    logic found;
    logic d_last;
    logic nb_in;
    logic nb_better;
    logic tr_stop;
    logic tr_out;
    logic out_free;
    logic em_last;
  } stat_t;

  // Offsets of the eight neighbours in row-major order, centre left out.
  function automatic logic signed [1:0] dir_dx(input logic [DIR_W-1:0] d);
    logic signed [1:0] r;
    case (d)
      3'd0, 3'd3, 3'd5: r = -2'sd1;
      3'd1, 3'd6:       r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [DIR_W-1:0] d);
    logic signed [1:0] r;
    case (d)
      3'd0, 3'd1, 3'd2: r = -2'sd1;
      3'd3, 3'd4:       r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/gops_ctrl.sv -----
// Controller state machine of the grid octile path search.
// Depends on gops_pkg for the command and status structs.
`timescale 1ns / 1ps

module gops_ctrl
  import gops_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_CLEAR, S_INIT, S_POP, S_POP_CHK, S_CUR_RD, S_CUR_LD,
    S_NB_SEL, S_NB_UPD, S_TR_INIT, S_TR_CHK, S_TR_STEP, S_APPEND, S_EM_RD,
    S_EM_LD, S_ERR_UNREACH, S_ERR_OVF
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad_req) begin
          state_next = S_ERR_UNREACH;
        end else begin
          cmd.clr_start = 1'b1;
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init_start = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        if (stat.q_empty) begin
          state_next = S_ERR_UNREACH;
        end else begin
          cmd.pop = 1'b1;
          state_next = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        cmd.pop_take = 1'b1;
        state_next = stat.found ? S_TR_INIT : S_CUR_RD;
      end
      S_CUR_RD: begin
        cmd.cur_rd = 1'b1;
        state_next = S_CUR_LD;
      end
      S_CUR_LD: begin
        cmd.cur_take = 1'b1;
        state_next = S_NB_SEL;
      end
      S_NB_SEL: begin
        if (stat.nb_in) begin
          cmd.nb_rd = 1'b1;
          state_next = S_NB_UPD;
        end else if (stat.d_last) begin
          state_next = S_POP;
        end else begin
          cmd.d_inc = 1'b1;
        end
      end
      S_NB_UPD: begin
        if (stat.nb_better && stat.q_full) begin
          state_next = S_ERR_OVF;
        end else begin
          cmd.nb_upd = 1'b1;
          if (stat.d_last) begin
            state_next = S_POP;
          end else begin
            cmd.d_inc = 1'b1;
            state_next = S_NB_SEL;
          end
        end
      end
      S_TR_INIT: begin
        cmd.tr_init = 1'b1;
        state_next = S_TR_CHK;
      end
      S_TR_CHK: begin
        if (stat.tr_stop) begin
          state_next = S_APPEND;
        end else begin
          cmd.tr_chk = 1'b1;
          state_next = S_TR_STEP;
        end
      end
      S_TR_STEP: begin
        if (stat.tr_out) begin
          state_next = S_APPEND;
        end else begin
          cmd.tr_step = 1'b1;
          state_next = S_TR_CHK;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_EM_RD;
      end
      S_EM_RD: begin
        cmd.em_rd = 1'b1;
        state_next = S_EM_LD;
      end
      S_EM_LD: begin
        if (stat.out_free) begin
          cmd.em_load = 1'b1;
          state_next = stat.em_last ? S_IDLE : S_EM_RD;
        end
      end
      S_ERR_UNREACH: begin
        if (stat.out_free) begin
          cmd.err_load = 1'b1;
          cmd.err_code = ST_UNREACH;
          state_next = S_IDLE;
        end
      end
      S_ERR_OVF: begin
        if (stat.out_free) begin
          cmd.err_load = 1'b1;
          cmd.err_code = ST_OVERFLOW;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/gops_dp.sv -----
// Datapath of the grid octile path search: config registers, cell store,
// work queue, path buffer and result register. Depends on gops_pkg.
`timescale 1ns / 1ps

module gops_dp
  import gops_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8192,
  parameter int MAX_PATH    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data,
  input  logic [COORD_W-1:0]   start_x,
  input  logic [COORD_W-1:0]   start_y,
  input  logic [COORD_W-1:0]   finish_x,
  input  logic [COORD_W-1:0]   finish_y,
  input  logic                 out_ready,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  output logic [COORD_W-1:0]   cell_x,
  output logic [COORD_W-1:0]   cell_y,
  output logic [1:0]           status,
  output logic                 last
);

  localparam int QA_W  = $clog2(QUEUE_DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PA_W  = $clog2(MAX_PATH);
  localparam int KC_W  = $clog2(MAX_PATH + 1);
  localparam int LEN_W = CELL_W + 1;
  localparam int WORD_W = 1 + DIR_W + COST_W;

  // Configuration and request registers.
  logic [SIDE_W-1:0]  grid_w_reg, grid_h_reg, w, h;
  logic [COORD_W-1:0] sx, sy, fx, fy;
  logic [CELL_W-1:0]  s_idx, f_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w_reg <= SIDE_W'(MAX_SIDE);
      grid_h_reg <= SIDE_W'(MAX_SIDE);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_w_reg <= cfg_data;
        REG_GRID_HEIGHT: grid_h_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w = (grid_w_reg == '0) ? SIDE_W'(1) :
        (grid_w_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_w_reg;
    h = (grid_h_reg == '0) ? SIDE_W'(1) :
        (grid_h_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_h_reg;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sx <= start_x;
      sy <= start_y;
      fx <= finish_x;
      fy <= finish_y;
    end
  end

  assign s_idx = {sy, sx};
  assign f_idx = {fy, fx};

  // Cell store: {seen, came-from direction, best cost}.
  logic [WORD_W-1:0] cell_mem [CELLS];
  logic [WORD_W-1:0] cell_rdata;
  logic [CELL_W-1:0] clr_cnt;
  logic [CELL_W-1:0] cur;
  logic [COST_W-1:0] cur_cost;
  logic [DIR_W-1:0]  dir_idx;

  // Neighbour of the current cell in the current direction.
  logic signed [1:0] dx, dy;
  logic signed [7:0] nx, ny;
  logic [CELL_W-1:0] ni;
  logic [COST_W-1:0] nc;
  logic              nb_better;

  assign dx = dir_dx(dir_idx);
  assign dy = dir_dy(dir_idx);
  assign nx = $signed({2'b00, cur[COORD_W-1:0]}) + $signed({{6{dx[1]}}, dx});
  assign ny = $signed({2'b00, cur[CELL_W-1:COORD_W]}) + $signed({{6{dy[1]}}, dy});
  assign ni = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
  assign nc = cur_cost + (((dx != 2'sd0) && (dy != 2'sd0)) ? STEP_DIAG : STEP_STRAIGHT);
  assign nb_better = !cell_rdata[WORD_W-1] || (nc < cell_rdata[COST_W-1:0]);

  // Work queue.
  logic [CELL_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [CELL_W-1:0] q_rdata;
  logic [QA_W-1:0]   head, tail;
  logic [QC_W-1:0]   q_count;
  logic              q_full, push;

  assign q_full = (q_count == QC_W'(QUEUE_DEPTH));
  assign push   = cmd.nb_upd && nb_better && !q_full;

  // Path trace: walk back from the finish into a circular path buffer.
  logic [COORD_W-1:0] px, py;
  logic [CELL_W-1:0]  len;
  logic [LEN_W-1:0]   total;
  logic signed [1:0]  tdx, tdy;
  logic signed [7:0]  npx, npy;
  logic [CELL_W-1:0]  chain_mem [MAX_PATH];
  logic [CELL_W-1:0]  chain_rdata;
  logic [PA_W-1:0]    wp, rp;
  logic [KC_W-1:0]    k_left;
  logic               trunc;

  assign tdx   = dir_dx(cell_rdata[WORD_W-2:COST_W]);
  assign tdy   = dir_dy(cell_rdata[WORD_W-2:COST_W]);
  assign npx   = $signed({2'b00, px}) - $signed({{6{tdx[1]}}, tdx});
  assign npy   = $signed({2'b00, py}) - $signed({{6{tdy[1]}}, tdy});
  assign total = {1'b0, len} + LEN_W'(1);

  // Cell store ports.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      cell_mem[clr_cnt] <= '0;
    end else if (cmd.init_start) begin
      cell_mem[s_idx] <= {1'b1, {DIR_W{1'b0}}, {COST_W{1'b0}}};
    end else if (cmd.nb_upd && nb_better) begin
      cell_mem[ni] <= {1'b1, dir_idx, nc};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_rd) begin
      cell_rdata <= cell_mem[cur];
    end else if (cmd.nb_rd) begin
      cell_rdata <= cell_mem[ni];
    end else if (cmd.tr_chk) begin
      cell_rdata <= cell_mem[{py, px}];
    end
  end

  // Queue ports.
  always_ff @(posedge clk) begin
    if (cmd.init_start) begin
      queue_mem[0] <= s_idx;
    end else if (push) begin
      queue_mem[tail] <= ni;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) q_rdata <= queue_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      q_count <= '0;
    end else if (cmd.init_start) begin
      head    <= '0;
      tail    <= QA_W'(1);
      q_count <= QC_W'(1);
    end else if (cmd.pop) begin
      head    <= (head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head + QA_W'(1);
      q_count <= q_count - QC_W'(1);
    end else if (push) begin
      tail    <= (tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail + QA_W'(1);
      q_count <= q_count + QC_W'(1);
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.clr_start) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + CELL_W'(1);
    end
    if (cmd.pop_take) cur <= q_rdata;
    if (cmd.cur_take) begin
      cur_cost <= cell_rdata[COST_W-1:0];
      dir_idx  <= '0;
    end else if (cmd.d_inc) begin
      dir_idx <= dir_idx + DIR_W'(1);
    end
  end

  // Trace and path buffer.
  always_ff @(posedge clk) begin
    if (cmd.tr_init) begin
      px  <= fx;
      py  <= fy;
      len <= '0;
      wp  <= '0;
    end else if (cmd.tr_chk) begin
      len <= len + CELL_W'(1);
      wp  <= (wp == PA_W'(MAX_PATH - 1)) ? '0 : wp + PA_W'(1);
    end else if (cmd.tr_step) begin
      px <= npx[COORD_W-1:0];
      py <= npy[COORD_W-1:0];
    end
    if (cmd.append) begin
      rp     <= wp;
      trunc  <= (total > LEN_W'(MAX_PATH));
      k_left <= (total > LEN_W'(MAX_PATH)) ? KC_W'(MAX_PATH) : KC_W'(total);
    end else if (cmd.em_load) begin
      rp     <= (rp == '0) ? PA_W'(MAX_PATH - 1) : rp - PA_W'(1);
      k_left <= k_left - KC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tr_chk) begin
      chain_mem[wp] <= {py, px};
    end else if (cmd.append) begin
      chain_mem[wp] <= s_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_rd) chain_rdata <= chain_mem[rp];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.em_load || cmd.err_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_load) begin
      cell_x <= chain_rdata[COORD_W-1:0];
      cell_y <= chain_rdata[CELL_W-1:COORD_W];
      status <= trunc ? ST_TRUNC : ST_FOUND;
      last   <= (k_left == KC_W'(1));
    end else if (cmd.err_load) begin
      cell_x <= '0;
      cell_y <= '0;
      status <= cmd.err_code;
      last   <= 1'b1;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.bad_req   = ({1'b0, sx} >= w) || ({1'b0, sy} >= h) ||
                     ({1'b0, fx} >= w) || ({1'b0, fy} >= h);
    stat.clr_done  = (clr_cnt == CELL_W'(CELLS - 1));
    stat.q_empty   = (q_count == '0);
    stat.q_full    = q_full;
    stat.found     = (q_rdata == f_idx);
    stat.d_last    = (dir_idx == DIR_W'(7));
    stat.nb_in     = !nx[7] && !ny[7] && (nx[SIDE_W-1:0] < w) && (ny[SIDE_W-1:0] < h);
    stat.nb_better = nb_better;
    stat.tr_stop   = ({py, px} == s_idx) || (len == CELL_W'(CELLS - 1));
    stat.tr_out    = npx[7] || npy[7] || (npx[SIDE_W-1:0] >= w) || (npy[SIDE_W-1:0] >= h);
    stat.out_free  = !out_valid || out_ready;
    stat.em_last   = (k_left == KC_W'(1));
  end

endmodule

// ----- rtl/grid_octile_path_search_top.sv -----
// Top level of the grid octile path search: controller plus datapath.
// Depends on gops_pkg, gops_ctrl and gops_dp.
`timescale 1ns / 1ps

// Shortest-path search on an open grid of grid_width by grid_height cells,
// eight-connected, with straight steps costing 1.0 and diagonal steps 1.414
// in unsigned Q16.16. One request (start and finish cells) is taken per
// transfer on the input channel; the path then leaves on the output channel
// one cell per transfer, start first, with last set on the final one. A
// request outside the grid or an unreachable finish gives a single transfer
// with status 1 and cell 0,0, and a work queue overflow a single transfer
// with status 2 and cell 0,0; a path longer than MAX_PATH cells gives its
// first MAX_PATH cells with status 3. Every request that lies inside the
// grid first clears the 4096-entry cell store, one entry per cycle. The
// search then pops cells from the work queue and checks their neighbours
// in turn, and cheaper costs push cells into the queue again; the trace
// back then walks from the finish to the start. The block takes a new
// request while the last result still waits on the output register. The
// user must write grid_width and grid_height only while the block is idle;
// the block does not enforce this. 0 acts as 1 and values above 64 act as
// 64.

module grid_octile_path_search_top
  import gops_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8192,
  parameter int MAX_PATH    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   start_x,
  input  logic [COORD_W-1:0]   start_y,
  input  logic [COORD_W-1:0]   finish_x,
  input  logic [COORD_W-1:0]   finish_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   cell_x,
  output logic [COORD_W-1:0]   cell_y,
  output logic [1:0]           status,
  output logic                 last
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences clear, search, trace and emission.
  gops_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath owns all stores, pointers and the result register.
  gops_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_PATH    (MAX_PATH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start_x   (start_x),
    .start_y   (start_y),
    .finish_x  (finish_x),
    .finish_y  (finish_y),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .status    (status),
    .last      (last)
  );

endmodule
